### rtl/gbts_pkg.sv
// ----------------------------------------------------------------------------
// gbts_pkg
// shared widths, operation and status codes, memory request type
// ----------------------------------------------------------------------------
`default_nettype none

package gbts_pkg;

    localparam int CAPACITY_DEF = 1024;

    localparam int OP_W     = 3;
    localparam int CHAR_W   = 8;
    localparam int POS_W    = 11;
    localparam int STAT_W   = 2;
    localparam int MEM_AW   = 16;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
    localparam logic [OP_W-1:0] OP_BACKSPACE = 3'd1;
    localparam logic [OP_W-1:0] OP_LEFT      = 3'd2;
    localparam logic [OP_W-1:0] OP_RIGHT     = 3'd3;
    localparam logic [OP_W-1:0] OP_MOVE      = 3'd4;
    localparam logic [OP_W-1:0] OP_READ      = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] waddr;
        logic [CHAR_W-1:0] wdata;
        logic              re;
        logic [MEM_AW-1:0] raddr;
    } mem_req_t;

endpackage

`default_nettype wire

### rtl/gbts_mem.sv
// ----------------------------------------------------------------------------
// gbts_mem
// text store, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module gbts_mem
    import gbts_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic              clk,
    input  wire mem_req_t          req,
    output logic      [CHAR_W-1:0] rdata
);

    localparam int ADDR_W = $clog2(CAPACITY);

    logic [CHAR_W-1:0] mem [CAPACITY];
    logic [CHAR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[ADDR_W-1:0]] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr[ADDR_W-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/gbts_ctrl.sv
// ----------------------------------------------------------------------------
// gbts_ctrl
// gap pointers, operation sequencer and result register
// ----------------------------------------------------------------------------
`default_nettype none

module gbts_ctrl
    import gbts_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [OP_W-1:0]   opcode,
    input  wire logic [CHAR_W-1:0] char_in,
    input  wire logic [POS_W-1:0]  position,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [STAT_W-1:0] status,
    output logic      [CHAR_W-1:0] char_out,
    output logic      [POS_W-1:0]  cursor_pos,
    output logic      [POS_W-1:0]  text_length,
    output mem_req_t               mem_req,
    input  wire logic [CHAR_W-1:0] mem_rdata
);

    localparam int PTR_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (PTR_W > POS_W) ? PTR_W : POS_W;
    localparam logic [PTR_W-1:0] CAP_PTR = PTR_W'(CAPACITY);
    localparam logic [PTR_W-1:0] ONE     = PTR_W'(1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LEFT  = 3'd1;
    localparam logic [2:0] S_RIGHT = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [PTR_W-1:0]  gs_reg, gs_next;
    logic [PTR_W-1:0]  ge_reg, ge_next;
    logic [PTR_W-1:0]  cnt_reg, cnt_next;
    logic [PTR_W-1:0]  target_reg, target_next;
    logic              move_reg, move_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [CHAR_W-1:0] char_reg, char_next;

    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic [POS_W-1:0]  out_cursor_reg, out_cursor_next;
    logic [POS_W-1:0]  out_length_reg, out_length_next;

    logic [PTR_W-1:0]  gs_inc, gs_dec, gs_dec2, ge_inc, ge_dec;
    logic [CMP_W-1:0]  pos_ext, cnt_ext;
    logic [PTR_W-1:0]  move_target, read_idx;
    logic              accept;

    assign gs_inc  = gs_reg + ONE;
    assign gs_dec  = gs_reg - ONE;
    assign gs_dec2 = gs_reg - PTR_W'(2);
    assign ge_inc  = ge_reg + ONE;
    assign ge_dec  = ge_reg - ONE;

    assign pos_ext     = CMP_W'(position);
    assign cnt_ext     = CMP_W'(cnt_reg);
    assign move_target = (pos_ext < cnt_ext) ? PTR_W'(position) : cnt_reg;
    assign read_idx    = (pos_ext < CMP_W'(gs_reg)) ? PTR_W'(position)
                                                    : PTR_W'(position) + (ge_reg - gs_reg);

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next      = state_reg;
        gs_next         = gs_reg;
        ge_next         = ge_reg;
        cnt_next        = cnt_reg;
        target_next     = target_reg;
        move_next       = move_reg;
        status_next     = status_reg;
        char_next       = char_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_char_next   = out_char_reg;
        out_cursor_next = out_cursor_reg;
        out_length_next = out_length_reg;
        mem_req         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_OK;
                    char_next   = '0;
                    move_next   = 1'b0;
                    state_next  = S_OUT;
                    unique case (opcode)
                        OP_INSERT:
                        begin
                            if (gs_reg == ge_reg)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = MEM_AW'(gs_reg);
                                mem_req.wdata = char_in;
                                gs_next       = gs_inc;
                                cnt_next      = cnt_reg + ONE;
                            end
                        end
                        OP_BACKSPACE:
                        begin
                            if (gs_reg == '0)
                            begin
                                status_next = ST_BOUND;
                            end
                            else
                            begin
                                gs_next  = gs_dec;
                                cnt_next = cnt_reg - ONE;
                            end
                        end
                        OP_LEFT:
                        begin
                            if (gs_reg == '0)
                            begin
                                status_next = ST_BOUND;
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = MEM_AW'(gs_dec);
                                state_next    = S_LEFT;
                            end
                        end
                        OP_RIGHT:
                        begin
                            if (ge_reg == CAP_PTR)
                            begin
                                status_next = ST_BOUND;
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = MEM_AW'(ge_reg);
                                state_next    = S_RIGHT;
                            end
                        end
                        OP_MOVE:
                        begin
                            target_next = move_target;
                            move_next   = 1'b1;
                            if (gs_reg > move_target)
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = MEM_AW'(gs_dec);
                                state_next    = S_LEFT;
                            end
                            else if (gs_reg < move_target)
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = MEM_AW'(ge_reg);
                                state_next    = S_RIGHT;
                            end
                        end
                        OP_READ:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = MEM_AW'(read_idx);
                                state_next    = S_READ;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_LEFT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = MEM_AW'(ge_dec);
                mem_req.wdata = mem_rdata;
                gs_next       = gs_dec;
                ge_next       = ge_dec;
                if (move_reg && (gs_dec > target_reg))
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = MEM_AW'(gs_dec2);
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_RIGHT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = MEM_AW'(gs_reg);
                mem_req.wdata = mem_rdata;
                gs_next       = gs_inc;
                ge_next       = ge_inc;
                if (move_reg && (gs_inc < target_reg))
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = MEM_AW'(ge_inc);
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_READ:
            begin
                char_next  = mem_rdata;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_char_next   = char_reg;
                    out_cursor_next = POS_W'(gs_reg);
                    out_length_next = POS_W'(cnt_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gs_reg        <= '0;
            ge_reg        <= CAP_PTR;
            cnt_reg       <= '0;
            move_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gs_reg        <= gs_next;
            ge_reg        <= ge_next;
            cnt_reg       <= cnt_next;
            move_reg      <= move_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg     <= target_next;
        status_reg     <= status_next;
        char_reg       <= char_next;
        out_status_reg <= out_status_next;
        out_char_reg   <= out_char_next;
        out_cursor_reg <= out_cursor_next;
        out_length_reg <= out_length_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign char_out    = out_char_reg;
    assign cursor_pos  = out_cursor_reg;
    assign text_length = out_length_reg;

endmodule

`default_nettype wire

### rtl/gap_buffer_text_store_core.sv
// ----------------------------------------------------------------------------
// gap_buffer_text_store_core
// fixed-capacity gap buffer text store with a stream command/result interface
//
// one item in on s_axis (opcode in tuser, byte and position in tdata) gives
// exactly one item out on m_axis (status in tuser, byte, cursor and length
// in tdata). the text lives in one single-port-write memory around a gap
// whose start is the cursor.
// insert, backspace and refused operations go straight to the output
// register; read passes through S_READ, left and right through S_LEFT or
// S_RIGHT; move carries one character across the gap per cycle through
// the memory read and write ports until the cursor reaches its target.
// a new item is taken once the previous one has reached the output
// register; a result waiting there does not block the next item, but a
// second result waits until m_axis_tready takes the first.
// reset empties the text (cursor and length zero); memory contents stay
// undefined and are never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module gap_buffer_text_store_core
    import gbts_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // char_in[7:0], position[18:8]
    input  wire logic [OP_W-1:0]      s_axis_tuser,   // opcode[2:0]
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [M_TDATA_W-1:0] m_axis_tdata,   // char_out[7:0], cursor_pos[18:8],
                                                      // text_length[29:19]
    output logic      [STAT_W-1:0]    m_axis_tuser    // status[1:0]
);

    mem_req_t          mem_req;
    logic [CHAR_W-1:0] mem_rdata;
    logic [CHAR_W-1:0] char_out;
    logic [POS_W-1:0]  cursor_pos;
    logic [POS_W-1:0]  text_length;

    gbts_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .opcode      (s_axis_tuser),
        .char_in     (s_axis_tdata[CHAR_W-1:0]),
        .position    (s_axis_tdata[CHAR_W+POS_W-1:CHAR_W]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .status      (m_axis_tuser),
        .char_out    (char_out),
        .cursor_pos  (cursor_pos),
        .text_length (text_length),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata)
    );

    gbts_mem #(
        .CAPACITY (CAPACITY)
    ) u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    assign m_axis_tdata = {2'b00, text_length, cursor_pos, char_out};

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for gap_buffer_text_store_core
//
// a short table of hand-picked edits (empty-text boundaries, clamped moves,
// out-of-range reads, unused opcodes) opens the run; then random edits in
// grow, shrink and mixed stretches, with one stretch that fills the store to
// capacity. a local copy of the gap buffer predicts each item, save table
// rows with their own result; results are compared field by field, in order.
// ----------------------------------------------------------------------------

module tb;
    import gbts_pkg::*;

    localparam int DEPTH      = CAPACITY_DEF;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int RAND_ITEMS = 1050;
    localparam int WATCHDOG   = 6000;
    localparam int TAIL       = 40;

    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    typedef enum int {MODE_MIX, MODE_GROW, MODE_SHRINK} mix_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  pos;
    } cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  cur;
        logic [POS_W-1:0]  len;
    } res_t;

    typedef struct {
        cmd_t c;
        bit   typed;
        res_t want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // char_in[7:0], position[18:8]
    logic [OP_W-1:0]      s_axis_tuser;   // opcode[2:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // char_out[7:0], cursor_pos[18:8],
                                          // text_length[29:19]
    logic [STAT_W-1:0]    m_axis_tuser;   // status[1:0]

    // local copy of the gap buffer
    logic [CHAR_W-1:0] text_copy [DEPTH];
    logic [POS_W-1:0]  gap_lo;
    logic [POS_W-1:0]  gap_hi;
    logic [POS_W-1:0]  n_chars;

    res_t      outcome_q [$];
    stim_row_t dir_rows [$];
    int        errors;
    bit        steady;

    gap_buffer_text_store_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void carry_left();
        gap_lo--;
        gap_hi--;
        text_copy[gap_hi[IDX_W-1:0]] = text_copy[gap_lo[IDX_W-1:0]];
    endfunction

    function automatic void carry_right();
        text_copy[gap_lo[IDX_W-1:0]] = text_copy[gap_hi[IDX_W-1:0]];
        gap_lo++;
        gap_hi++;
    endfunction

    function automatic res_t edit_outcome(cmd_t c);
        res_t             r;
        logic [POS_W-1:0] goal;
        int               idx;
        r.status = ST_OK;
        r.ch     = '0;
        case (c.op)
            OP_INSERT:
                if (gap_lo == gap_hi)
                    r.status = ST_FULL;
                else
                begin
                    text_copy[gap_lo[IDX_W-1:0]] = c.ch;
                    gap_lo++;
                    n_chars++;
                end
            OP_BACKSPACE:
                if (gap_lo == 0)
                    r.status = ST_BOUND;
                else
                begin
                    gap_lo--;
                    n_chars--;
                end
            OP_LEFT:
                if (gap_lo == 0)
                    r.status = ST_BOUND;
                else
                    carry_left();
            OP_RIGHT:
                if (gap_hi == DEPTH)
                    r.status = ST_BOUND;
                else
                    carry_right();
            OP_MOVE:
            begin
                goal = (c.pos < n_chars) ? c.pos : n_chars;
                while (gap_lo > goal)
                    carry_left();
                while (gap_lo < goal)
                    carry_right();
            end
            OP_READ:
                if (c.pos >= n_chars)
                    r.status = ST_RANGE;
                else
                begin
                    idx = (c.pos < gap_lo) ? int'(c.pos)
                                           : int'(c.pos) + int'(gap_hi) - int'(gap_lo);
                    r.ch = text_copy[idx[IDX_W-1:0]];
                end
            default: ;
        endcase
        r.cur = gap_lo;
        r.len = n_chars;
        return r;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [OP_W-1:0] pick_op(mix_t mode);
        int r, ins, bs, lt, rt, mv, rd;
        case (mode)
            MODE_GROW:   begin ins = 65; bs = 3;  lt = 5;  rt = 5;  mv = 5;  rd = 15; end
            MODE_SHRINK: begin ins = 3;  bs = 45; lt = 10; rt = 10; mv = 15; rd = 15; end
            default:     begin ins = 30; bs = 10; lt = 12; rt = 12; mv = 10; rd = 22; end
        endcase
        r = $urandom_range(0, 99);
        if (r < ins) return OP_INSERT;
        r -= ins;
        if (r < bs) return OP_BACKSPACE;
        r -= bs;
        if (r < lt) return OP_LEFT;
        r -= lt;
        if (r < rt) return OP_RIGHT;
        r -= rt;
        if (r < mv) return OP_MOVE;
        r -= mv;
        if (r < rd) return OP_READ;
        return $urandom_range(0, 1) ? OP_SPARE7 : OP_SPARE6;
    endfunction

    // reads mostly inside the text, moves mostly near the cursor
    function automatic logic [POS_W-1:0] pick_spot(logic [OP_W-1:0] op);
        int r, p;
        r = $urandom_range(0, 99);
        if (r < 5)
            return POS_W'($urandom_range(0, 2047));
        if (op == OP_READ)
        begin
            if (r < 85 && n_chars > 0)
                p = $urandom_range(0, int'(n_chars) - 1);
            else
                p = int'(n_chars) + $urandom_range(0, 3);
        end
        else if (r < 75)
        begin
            p = int'(gap_lo) + int'($urandom_range(0, 16)) - 8;
            if (p < 0)
                p = 0;
        end
        else
            p = $urandom_range(0, int'(n_chars) + 4);
        return p[POS_W-1:0];
    endfunction

    function automatic cmd_t rand_cmd(mix_t mode);
        cmd_t c;
        c.op  = pick_op(mode);
        c.ch  = CHAR_W'($urandom_range(0, 255));
        c.pos = pick_spot(c.op);
        return c;
    endfunction

    task automatic issue(cmd_t c, bit typed, res_t want);
        res_t guess;
        int   idle;
        idle = steady ? 0 : pick_gap();
        if (idle > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W-CHAR_W-POS_W){1'b0}}, c.pos, c.ch};
        s_axis_tuser  <= c.op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        guess = edit_outcome(c);
        outcome_q.push_back(typed ? want : guess);
    endtask

    task automatic issue_rand(cmd_t c);
        issue(c, 1'b0, '0);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outcome_q.size() != 0);
    endtask

    task automatic add_row(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                           logic [POS_W-1:0] pos, bit typed,
                           logic [STAT_W-1:0] st, logic [CHAR_W-1:0] ch_o,
                           logic [POS_W-1:0] cur, logic [POS_W-1:0] len);
        stim_row_t row;
        row.c.op        = op;
        row.c.ch        = ch;
        row.c.pos       = pos;
        row.typed       = typed;
        row.want.status = st;
        row.want.ch     = ch_o;
        row.want.cur    = cur;
        row.want.len    = len;
        dir_rows.push_back(row);
    endtask

    task automatic check_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
        if (got !== want)
        begin
            if (errors < 50)
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic take_result();
        res_t got;
        res_t want;
        got.status = m_axis_tuser;
        got.ch     = m_axis_tdata[CHAR_W-1:0];
        got.cur    = m_axis_tdata[CHAR_W +: POS_W];
        got.len    = m_axis_tdata[CHAR_W+POS_W +: POS_W];
        if (outcome_q.size() == 0)
        begin
            if (errors < 50)
                $display("%0t: unexpected item, expected none actual status %0d cursor %0d",
                         $time, got.status, got.cur);
            errors++;
        end
        else
        begin
            want = outcome_q.pop_front();
            check_field("status", POS_W'(want.status), POS_W'(got.status));
            check_field("char_out", POS_W'(want.ch), POS_W'(got.ch));
            check_field("cursor_pos", want.cur, got.cur);
            check_field("text_length", want.len, got.len);
        end
    endtask

    // result side
    initial
    begin
        int hold;
        hold = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                take_result();
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else if (steady)
                m_axis_tready <= 1'b1;
            else
            begin
                hold = pick_gap();
                m_axis_tready <= (hold == 0);
            end
        end
    end

    // watchdog on cycles with no item moving either way
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int   sent;
        int   seg;
        mix_t mode;
        bit   filled;
        errors        = 0;
        steady        = 1'b0;
        filled        = 1'b0;
        sent          = 0;
        gap_lo        = '0;
        gap_hi        = POS_W'(DEPTH);
        n_chars       = '0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_INSERT;

        // empty text boundaries first, then a three-byte text
        add_row(OP_READ,      8'h00, 11'd0,    1'b1, ST_RANGE, 8'h00, 11'd0, 11'd0);
        add_row(OP_BACKSPACE, 8'h00, 11'd0,    1'b1, ST_BOUND, 8'h00, 11'd0, 11'd0);
        add_row(OP_LEFT,      8'h00, 11'd0,    1'b1, ST_BOUND, 8'h00, 11'd0, 11'd0);
        add_row(OP_RIGHT,     8'h00, 11'd0,    1'b1, ST_BOUND, 8'h00, 11'd0, 11'd0);
        add_row(OP_MOVE,      8'h00, 11'd2047, 1'b1, ST_OK,    8'h00, 11'd0, 11'd0);
        add_row(OP_INSERT,    8'h00, 11'd0,    1'b1, ST_OK,    8'h00, 11'd1, 11'd1);
        add_row(OP_INSERT,    8'hFF, 11'd2047, 1'b1, ST_OK,    8'h00, 11'd2, 11'd2);
        add_row(OP_INSERT,    8'h5A, 11'd0,    1'b1, ST_OK,    8'h00, 11'd3, 11'd3);
        add_row(OP_READ,      8'h00, 11'd0,    1'b1, ST_OK,    8'h00, 11'd3, 11'd3);
        add_row(OP_READ,      8'h00, 11'd1,    1'b1, ST_OK,    8'hFF, 11'd3, 11'd3);
        add_row(OP_READ,      8'h00, 11'd3,    1'b1, ST_RANGE, 8'h00, 11'd3, 11'd3);
        add_row(OP_READ,      8'hFF, 11'd2047, 1'b1, ST_RANGE, 8'h00, 11'd3, 11'd3);
        add_row(OP_LEFT,      8'h00, 11'd0,    1'b1, ST_OK,    8'h00, 11'd2, 11'd3);
        add_row(OP_LEFT,      8'h00, 11'd0,    1'b1, ST_OK,    8'h00, 11'd1, 11'd3);
        add_row(OP_READ,      8'h00, 11'd2,    1'b1, ST_OK,    8'h5A, 11'd1, 11'd3);
        add_row(OP_INSERT,    8'h81, 11'd0,    1'b0, ST_OK,    8'h00, 11'd0, 11'd0);
        add_row(OP_MOVE,      8'h00, 11'd0,    1'b0, ST_OK,    8'h00, 11'd0, 11'd0);
        add_row(OP_LEFT,      8'h00, 11'd0,    1'b1, ST_BOUND, 8'h00, 11'd0, 11'd4);
        add_row(OP_MOVE,      8'h00, 11'd1024, 1'b0, ST_OK,    8'h00, 11'd0, 11'd0);
        add_row(OP_RIGHT,     8'h00, 11'd0,    1'b1, ST_BOUND, 8'h00, 11'd4, 11'd4);
        add_row(OP_BACKSPACE, 8'h00, 11'd0,    1'b0, ST_OK,    8'h00, 11'd0, 11'd0);
        add_row(OP_SPARE6,    8'hFF, 11'd2047, 1'b0, ST_OK,    8'h00, 11'd0, 11'd0);
        add_row(OP_SPARE7,    8'h00, 11'd0,    1'b0, ST_OK,    8'h00, 11'd0, 11'd0);
        add_row(OP_READ,      8'h00, 11'd1,    1'b0, ST_OK,    8'h00, 11'd0, 11'd0);
        add_row(OP_MOVE,      8'h00, 11'd1,    1'b0, ST_OK,    8'h00, 11'd0, 11'd0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            issue(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);
        drain();

        while (sent < RAND_ITEMS)
        begin
            case ($urandom_range(0, 2))
                0:       mode = MODE_GROW;
                1:       mode = MODE_SHRINK;
                default: mode = MODE_MIX;
            endcase
            steady = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 3) == 0)
                drain();

            // one stretch that fills the store, then edits against a full store
            if (!filled && sent >= RAND_ITEMS / 32)
            begin
                filled = 1'b1;
                while (n_chars < DEPTH)
                begin
                    issue_rand('{OP_INSERT, 8'($urandom_range(0, 255)), 11'd0});
                    sent++;
                end
                repeat (3)
                begin
                    issue_rand('{OP_INSERT, 8'($urandom_range(0, 255)), 11'd0});
                    sent++;
                end
                issue_rand('{OP_MOVE, 8'h00, 11'($urandom_range(0, DEPTH))});
                issue_rand('{OP_INSERT, 8'hC3, 11'd0});
                issue_rand('{OP_LEFT, 8'h00, 11'd0});
                issue_rand('{OP_RIGHT, 8'h00, 11'd0});
                issue_rand('{OP_READ, 8'h00, 11'(DEPTH - 1)});
                issue_rand('{OP_READ, 8'h00, 11'(DEPTH)});
                issue_rand('{OP_MOVE, 8'h00, 11'(DEPTH)});
                issue_rand('{OP_RIGHT, 8'h00, 11'd0});
                sent += 8;
                mode = MODE_SHRINK;
            end

            seg = $urandom_range(20, 80);
            repeat (seg)
            begin
                issue_rand(rand_cmd(mode));
                sent++;
            end
        end

        steady = 1'b0;
        drain();
        repeat (TAIL) @(posedge clk);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

### files.f
rtl/gbts_pkg.sv
rtl/gbts_mem.sv
rtl/gbts_ctrl.sv
rtl/gap_buffer_text_store_core.sv
test/tb.sv
